FILE: rtl/aarm_pkg.sv
// package for the axis-angle rotation matrix block
// holds widths, item structs and the cordic arctangent table; no dependencies
package aarm_pkg;

	localparam int AXIS_BITS = 16;
	localparam int ANGLE_BITS = 16;
	localparam int OUT_BITS = 16;
	localparam int UFRAC = 20;
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_GAIN = 652032875;
	localparam int ROOT_BITS = 33;
	localparam int QUO_BITS = UFRAC + 1;

	typedef struct packed {
		logic signed [AXIS_BITS-1:0] axis_x;
		logic signed [AXIS_BITS-1:0] axis_y;
		logic signed [AXIS_BITS-1:0] axis_z;
		logic [ANGLE_BITS-1:0] turn_angle;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] m00;
		logic signed [OUT_BITS-1:0] m01;
		logic signed [OUT_BITS-1:0] m02;
		logic signed [OUT_BITS-1:0] m10;
		logic signed [OUT_BITS-1:0] m11;
		logic signed [OUT_BITS-1:0] m12;
		logic signed [OUT_BITS-1:0] m20;
		logic signed [OUT_BITS-1:0] m21;
		logic signed [OUT_BITS-1:0] m22;
	} out_item_t;

	function automatic logic [31:0] atan_unit(input logic [4:0] i);
		logic [31:0] t;
		case (i)
			5'd0: t = 32'h20000000;
			5'd1: t = 32'h12E4051D;
			5'd2: t = 32'h09FB385B;
			5'd3: t = 32'h051111D4;
			5'd4: t = 32'h028B0D43;
			5'd5: t = 32'h0145D7E1;
			5'd6: t = 32'h00A2F61E;
			5'd7: t = 32'h00517C55;
			5'd8: t = 32'h0028BE53;
			5'd9: t = 32'h00145F2F;
			5'd10: t = 32'h000A2F98;
			5'd11: t = 32'h000517CC;
			5'd12: t = 32'h00028BE6;
			5'd13: t = 32'h000145F3;
			5'd14: t = 32'h0000A2F9;
			5'd15: t = 32'h0000517C;
			5'd16: t = 32'h000028BE;
			5'd17: t = 32'h0000145F;
			5'd18: t = 32'h00000A2F;
			5'd19: t = 32'h00000517;
			5'd20: t = 32'h0000028B;
			5'd21: t = 32'h00000145;
			5'd22: t = 32'h000000A2;
			5'd23: t = 32'h00000051;
			5'd24: t = 32'h00000028;
			5'd25: t = 32'h00000014;
			5'd26: t = 32'h0000000A;
			5'd27: t = 32'h00000005;
			5'd28: t = 32'h00000002;
			5'd29: t = 32'h00000001;
			default: t = 32'h0;
		endcase
		return t;
	endfunction

endpackage

FILE: rtl/aarm_cordic.sv
// pipelined cordic, one rotation per stage, then quadrant map and q20 rounding
// depends on aarm_pkg
module aarm_cordic import aarm_pkg::*; (
	input  logic clk,
	input  logic [ANGLE_BITS-1:0] angle,
	output logic signed [21:0] cos_q20,
	output logic signed [21:0] sin_q20
);
	logic signed [33:0] x_s [CORDIC_STEPS+1];
	logic signed [33:0] y_s [CORDIC_STEPS+1];
	logic signed [33:0] z_s [CORDIC_STEPS+1];
	logic [1:0] q_s [CORDIC_STEPS+1];
	logic signed [21:0] c_s1, s_s1;

	logic [31:0] theta, d;
	logic [1:0] q0;

	assign theta = {angle, {(32-ANGLE_BITS){1'b0}}};
	assign q0 = 2'((theta + 32'h20000000) >> 30);
	assign d = theta - {q0, 30'd0};

	always_ff @(posedge clk) begin
		x_s[0] <= 34'(CORDIC_GAIN);
		y_s[0] <= '0;
		z_s[0] <= 34'(signed'(d));
		q_s[0] <= q0;
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			q_s[i+1] <= q_s[i];
			if (!z_s[i][33]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - 34'(atan_unit(5'(i)));
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + 34'(atan_unit(5'(i)));
			end
		end
	end

	logic signed [33:0] cx, sy, cr, sr;
	always_comb begin
		case (q_s[CORDIC_STEPS])
			2'd0: begin cx = x_s[CORDIC_STEPS]; sy = y_s[CORDIC_STEPS]; end
			2'd1: begin cx = -y_s[CORDIC_STEPS]; sy = x_s[CORDIC_STEPS]; end
			2'd2: begin cx = -x_s[CORDIC_STEPS]; sy = -y_s[CORDIC_STEPS]; end
			default: begin cx = y_s[CORDIC_STEPS]; sy = -x_s[CORDIC_STEPS]; end
		endcase
		cr = (cx + 34'sd512) >>> 10;
		sr = (sy + 34'sd512) >>> 10;
	end

	always_ff @(posedge clk) begin
		c_s1 <= 22'(cr);
		s_s1 <= 22'(sr);
	end

	assign cos_q20 = c_s1;
	assign sin_q20 = s_s1;
endmodule

FILE: rtl/aarm_norm.sv
// axis normalizer: shift up, sum of squares, pipelined integer root,
// then pipelined restoring divides for the three unit components; uses aarm_pkg
module aarm_norm import aarm_pkg::*; (
	input  logic clk,
	input  logic signed [AXIS_BITS-1:0] ax,
	input  logic signed [AXIS_BITS-1:0] ay,
	input  logic signed [AXIS_BITS-1:0] az,
	output logic signed [21:0] ux,
	output logic signed [21:0] uy,
	output logic signed [21:0] uz
);
	localparam int SQ = ROOT_BITS - 1;

	// stage 1: magnitudes and normalizing shift
	logic [AXIS_BITS-1:0] m0, m1, m2, mx;
	logic [4:0] lz;
	always_comb begin
		m0 = ax[AXIS_BITS-1] ? AXIS_BITS'(-ax) : AXIS_BITS'(ax);
		m1 = ay[AXIS_BITS-1] ? AXIS_BITS'(-ay) : AXIS_BITS'(ay);
		m2 = az[AXIS_BITS-1] ? AXIS_BITS'(-az) : AXIS_BITS'(az);
		mx = m0 | m1 | m2;
		lz = '0;
		for (int b = 0; b < AXIS_BITS; b++)
			if (mx[b]) lz = 5'(30 - b);
	end

	logic [30:0] a_s1 [3];
	logic [2:0] neg_s1;
	logic zero_s1;
	always_ff @(posedge clk) begin
		a_s1[0] <= 31'(m0) << lz;
		a_s1[1] <= 31'(m1) << lz;
		a_s1[2] <= 31'(m2) << lz;
		neg_s1 <= {az[AXIS_BITS-1], ay[AXIS_BITS-1], ax[AXIS_BITS-1]};
		zero_s1 <= (mx == '0);
	end

	// stage 2: sum of squares
	logic [63:0] sq_s2;
	logic [30:0] a_s2 [3];
	logic [2:0] neg_s2;
	logic zero_s2;
	always_ff @(posedge clk) begin
		sq_s2 <= 64'(a_s1[0]) * 64'(a_s1[0]) + 64'(a_s1[1]) * 64'(a_s1[1])
			+ 64'(a_s1[2]) * 64'(a_s1[2]);
		a_s2 <= a_s1;
		neg_s2 <= neg_s1;
		zero_s2 <= zero_s1;
	end

	// root: one result bit per stage
	logic [63:0] rem_r [SQ+1];
	logic [ROOT_BITS-1:0] root_r [SQ+1];
	logic [30:0] a_r [SQ+1][3];
	logic [2:0] neg_r [SQ+1];
	logic zero_r [SQ+1];
	always_comb begin
		rem_r[0] = sq_s2;
		root_r[0] = '0;
		a_r[0] = a_s2;
		neg_r[0] = neg_s2;
		zero_r[0] = zero_s2;
	end
	for (genvar k = 0; k < SQ; k++) begin : g_root
		logic [ROOT_BITS-1:0] trial;
		logic [65:0] tsq;
		assign trial = root_r[k] | (ROOT_BITS'(1) << (SQ - 1 - k));
		assign tsq = 66'(trial) * 66'(trial);
		always_ff @(posedge clk) begin
			root_r[k+1] <= (tsq <= 66'(rem_r[k])) ? trial : root_r[k];
			rem_r[k+1] <= rem_r[k];
			a_r[k+1] <= a_r[k];
			neg_r[k+1] <= neg_r[k];
			zero_r[k+1] <= zero_r[k];
		end
	end

	// divide: numerator a*2^20 + r/2, one quotient bit per stage
	localparam int NB = 52;
	logic [NB-1:0] num_d [3][QUO_BITS+1];
	logic [QUO_BITS-1:0] quo_d [3][QUO_BITS+1];
	logic [ROOT_BITS-1:0] r_d [QUO_BITS+1];
	logic [2:0] neg_d [QUO_BITS+1];
	logic zero_d [QUO_BITS+1];
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			num_d[c][0] = (NB'(a_r[SQ][c]) << UFRAC) + NB'(root_r[SQ] >> 1);
			quo_d[c][0] = '0;
		end
		r_d[0] = root_r[SQ];
		neg_d[0] = neg_r[SQ];
		zero_d[0] = zero_r[SQ];
	end
	for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
		for (genvar c = 0; c < 3; c++) begin : g_ch
			logic [NB-1:0] sub;
			logic fits;
			assign sub = NB'(r_d[k]) << (QUO_BITS - 1 - k);
			assign fits = (r_d[k] != '0) && (num_d[c][k] >= sub);
			always_ff @(posedge clk) begin
				num_d[c][k+1] <= fits ? num_d[c][k] - sub : num_d[c][k];
				quo_d[c][k+1] <= fits ? (quo_d[c][k] | (QUO_BITS'(1) << (QUO_BITS-1-k)))
					: quo_d[c][k];
			end
		end
		always_ff @(posedge clk) begin
			r_d[k+1] <= r_d[k];
			neg_d[k+1] <= neg_d[k];
			zero_d[k+1] <= zero_d[k];
		end
	end

	logic signed [21:0] u [3];
	always_comb begin
		for (int c = 0; c < 3; c++)
			u[c] = neg_d[QUO_BITS][c] ? -22'(quo_d[c][QUO_BITS]) : 22'(quo_d[c][QUO_BITS]);
	end
	assign ux = zero_d[QUO_BITS] ? 22'sd1048576 : u[0];
	assign uy = zero_d[QUO_BITS] ? 22'sd0 : u[1];
	assign uz = zero_d[QUO_BITS] ? 22'sd0 : u[2];
endmodule

FILE: rtl/aarm_matrix.sv
// rodrigues matrix entries from unit axis and sine/cosine, three stages
// depends on aarm_pkg
module aarm_matrix import aarm_pkg::*; (
	input  logic clk,
	input  logic signed [21:0] ux,
	input  logic signed [21:0] uy,
	input  logic signed [21:0] uz,
	input  logic signed [21:0] c,
	input  logic signed [21:0] s,
	output out_item_t mat
);
	localparam int SH = 61 - OUT_BITS;

	// stage 1: products of axis pairs and sine terms
	logic signed [43:0] p_s1 [6];
	logic signed [43:0] t_s1 [3];
	logic signed [22:0] mc_s1;
	logic signed [21:0] c_s1;
	always_ff @(posedge clk) begin
		p_s1[0] <= ux * ux; p_s1[1] <= uy * uy; p_s1[2] <= uz * uz;
		p_s1[3] <= ux * uy; p_s1[4] <= ux * uz; p_s1[5] <= uy * uz;
		t_s1[0] <= ux * s; t_s1[1] <= uy * s; t_s1[2] <= uz * s;
		mc_s1 <= 23'sd1048576 - 23'(c);
		c_s1 <= c;
	end

	// stage 2: scale by 1-c, widen into q60
	logic signed [67:0] p_s2 [6];
	logic signed [67:0] t_s2 [3];
	logic signed [67:0] cs_s2;
	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++) p_s2[i] <= 68'(p_s1[i]) * 68'(mc_s1);
		for (int i = 0; i < 3; i++) t_s2[i] <= 68'(t_s1[i]) <<< UFRAC;
		cs_s2 <= 68'(c_s1) <<< 40;
	end

	function automatic logic signed [OUT_BITS-1:0] fin(input logic signed [67:0] v);
		logic signed [67:0] r;
		r = (v + (68'sd1 <<< (SH - 1))) >>> SH;
		if (r > 68'sd0 + ((68'sd1 <<< (OUT_BITS - 1)) - 1))
			return {1'b0, {(OUT_BITS-1){1'b1}}};
		if (r < -(68'sd1 <<< (OUT_BITS - 1)))
			return {1'b1, {(OUT_BITS-1){1'b0}}};
		return OUT_BITS'(r);
	endfunction

	// stage 3: sums, round and saturate
	always_ff @(posedge clk) begin
		mat.m00 <= fin(cs_s2 + p_s2[0]);
		mat.m01 <= fin(p_s2[3] - t_s2[2]);
		mat.m02 <= fin(p_s2[4] + t_s2[1]);
		mat.m10 <= fin(p_s2[3] + t_s2[2]);
		mat.m11 <= fin(cs_s2 + p_s2[1]);
		mat.m12 <= fin(p_s2[5] - t_s2[0]);
		mat.m20 <= fin(p_s2[4] - t_s2[1]);
		mat.m21 <= fin(p_s2[5] + t_s2[0]);
		mat.m22 <= fin(cs_s2 + p_s2[2]);
	end
endmodule

FILE: rtl/axis_angle_rotation_matrix.sv
// axis-angle rotation matrix top level: normalizer, cordic and matrix stages
// depends on aarm_pkg, aarm_norm, aarm_cordic, aarm_matrix
//
// usage: drive req with an axis and angle and raise start; busy is always
// low, so an item is taken at every edge where start is high.
// one result item appears on rsp with done high for exactly one cycle.
// pipeline: 2 normalizer front stages, 32 root stages, 21 divide stages and
// 3 matrix stages; the angle path is delayed to match.
// throughput: one item per cycle, fixed by the fully pipelined root and
// divide chains (one result bit per stage).
// reset clears only the valid pipeline; no item is lost or repeated since
// the receiver cannot stall and nothing else holds items back.
// zero-length axis gives the rotation about the unit x axis.
module axis_angle_rotation_matrix import aarm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_item_t req,
	output logic done,
	output out_item_t rsp
);
	localparam int NORM_LAT = 2 + (ROOT_BITS - 1) + QUO_BITS;
	localparam int CORD_LAT = CORDIC_STEPS + 2;
	localparam int ALIGN = NORM_LAT - CORD_LAT;
	localparam int LAT = NORM_LAT + 3;

	logic signed [21:0] ux, uy, uz, c, s;
	logic signed [21:0] cd_s [ALIGN+1];
	logic signed [21:0] sd_s [ALIGN+1];
	logic [LAT-1:0] vld_q;

	assign busy = 1'b0;

	aarm_norm u_norm (
		.clk(clk), .ax(req.axis_x), .ay(req.axis_y), .az(req.axis_z),
		.ux(ux), .uy(uy), .uz(uz)
	);

	aarm_cordic u_cordic (
		.clk(clk), .angle(req.turn_angle),
		.cos_q20(cd_s[0]), .sin_q20(sd_s[0])
	);

	for (genvar k = 0; k < ALIGN; k++) begin : g_align
		always_ff @(posedge clk) begin
			cd_s[k+1] <= cd_s[k];
			sd_s[k+1] <= sd_s[k];
		end
	end
	assign c = cd_s[ALIGN];
	assign s = sd_s[ALIGN];

	aarm_matrix u_matrix (
		.clk(clk), .ux(ux), .uy(uy), .uz(uz), .c(c), .s(s), .mat(rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end
	assign done = vld_q[LAT-1];

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(LAT) done) else $error("item lost in pipeline");
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT)) else $error("result without item");
	a_never_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
`endif
endmodule

FILE: dv/testbench.sv
// self-checking testbench for axis_angle_rotation_matrix
// predicts each rotation matrix in fixed point and compares it with the block
// depends on aarm_pkg and the rtl of axis_angle_rotation_matrix
`timescale 1ns / 1ps

module testbench;
	import aarm_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	in_item_t req = '0;
	out_item_t rsp;

	in_item_t pending_items[$];
	out_item_t expected_matrices[$];
	int unsigned mismatches = 0;
	bit drain_hold = 1'b0;
	int idle_pct = 33;

	axis_angle_rotation_matrix DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint shr_floor(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n)
			bit_v >>= 2;
		while (bit_v != 0) begin
			if (n >= res + bit_v) begin
				n -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [OUT_BITS-1:0] round_sat(longint v);
		longint r, hi, lo;
		hi = (64'sd1 <<< (OUT_BITS - 1)) - 1;
		lo = -(64'sd1 <<< (OUT_BITS - 1));
		r = shr_floor(v + (64'sd1 <<< (60 - OUT_BITS)), 61 - OUT_BITS);
		if (r > hi)
			r = hi;
		if (r < lo)
			r = lo;
		return r[OUT_BITS-1:0];
	endfunction

	function automatic out_item_t rotation_matrix(in_item_t it);
		longint v[3], u[3];
		longint unsigned a[3], mx, mag2, r, quo;
		logic [31:0] theta, qd, dres;
		logic [1:0] q;
		longint x, y, z, dx, dy, cx, sy, c, s, mc, cs;
		longint one20;
		out_item_t m;
		one20 = 64'sd1 <<< UFRAC;
		v[0] = it.axis_x;
		v[1] = it.axis_y;
		v[2] = it.axis_z;
		mx = 0;
		mag2 = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = v[i] < 0 ? -v[i] : v[i];
			if (a[i] > mx)
				mx = a[i];
		end
		if (mx == 0) begin
			u[0] = one20;
			u[1] = 0;
			u[2] = 0;
		end else begin
			while (mx < (64'd1 << 30)) begin
				mx <<= 1;
				for (int i = 0; i < 3; i++)
					a[i] <<= 1;
			end
			for (int i = 0; i < 3; i++)
				mag2 += a[i] * a[i];
			r = root64(mag2);
			for (int i = 0; i < 3; i++) begin
				quo = ((a[i] << UFRAC) + (r >> 1)) / r;
				u[i] = v[i] < 0 ? -longint'(quo) : longint'(quo);
			end
		end
		theta = {it.turn_angle, {(32 - ANGLE_BITS){1'b0}}};
		qd = theta + 32'h20000000;
		q = qd[31:30];
		dres = theta - {q, 30'd0};
		z = longint'(signed'(dres));
		x = CORDIC_GAIN;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_unit(5'(i)));
			end else begin
				x += dx; y -= dy; z += longint'(atan_unit(5'(i)));
			end
		end
		case (q)
			2'd0: begin cx = x; sy = y; end
			2'd1: begin cx = -y; sy = x; end
			2'd2: begin cx = -x; sy = -y; end
			default: begin cx = y; sy = -x; end
		endcase
		c = shr_floor(cx + 512, 10);
		s = shr_floor(sy + 512, 10);
		mc = one20 - c;
		cs = c * (64'sd1 <<< 40);
		m.m00 = round_sat(cs + u[0] * u[0] * mc);
		m.m01 = round_sat(u[0] * u[1] * mc - u[2] * s * one20);
		m.m02 = round_sat(u[0] * u[2] * mc + u[1] * s * one20);
		m.m10 = round_sat(u[0] * u[1] * mc + u[2] * s * one20);
		m.m11 = round_sat(cs + u[1] * u[1] * mc);
		m.m12 = round_sat(u[1] * u[2] * mc - u[0] * s * one20);
		m.m20 = round_sat(u[0] * u[2] * mc - u[1] * s * one20);
		m.m21 = round_sat(u[1] * u[2] * mc + u[0] * s * one20);
		m.m22 = round_sat(cs + u[2] * u[2] * mc);
		return m;
	endfunction

	function automatic logic [15:0] rand_component();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 4)) - 16'd2;
			default: return 16'($urandom);
		endcase
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n && !(start && busy)) begin
			if (pending_items.size() > 0 && !drain_hold
					&& $urandom_range(0, 99) >= idle_pct) begin
				req <= pending_items.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// accept and predict
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			expected_matrices.push_back(rotation_matrix(req));
	end

	// monitor
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (expected_matrices.size() == 0) begin
				$display("%0t: unexpected item %h", $time, rsp);
				mismatches++;
			end else begin
				want = expected_matrices.pop_front();
				if (rsp.m00 !== want.m00) begin
					$display("%0t m00 exp %0d got %0d", $time, want.m00, rsp.m00); mismatches++; end
				if (rsp.m01 !== want.m01) begin
					$display("%0t m01 exp %0d got %0d", $time, want.m01, rsp.m01); mismatches++; end
				if (rsp.m02 !== want.m02) begin
					$display("%0t m02 exp %0d got %0d", $time, want.m02, rsp.m02); mismatches++; end
				if (rsp.m10 !== want.m10) begin
					$display("%0t m10 exp %0d got %0d", $time, want.m10, rsp.m10); mismatches++; end
				if (rsp.m11 !== want.m11) begin
					$display("%0t m11 exp %0d got %0d", $time, want.m11, rsp.m11); mismatches++; end
				if (rsp.m12 !== want.m12) begin
					$display("%0t m12 exp %0d got %0d", $time, want.m12, rsp.m12); mismatches++; end
				if (rsp.m20 !== want.m20) begin
					$display("%0t m20 exp %0d got %0d", $time, want.m20, rsp.m20); mismatches++; end
				if (rsp.m21 !== want.m21) begin
					$display("%0t m21 exp %0d got %0d", $time, want.m21, rsp.m21); mismatches++; end
				if (rsp.m22 !== want.m22) begin
					$display("%0t m22 exp %0d got %0d", $time, want.m22, rsp.m22); mismatches++; end
			end
		end
	end

	task automatic add_item(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
			logic [15:0] ang);
		in_item_t it;
		it.axis_x = ax;
		it.axis_y = ay;
		it.axis_z = az;
		it.turn_angle = ang;
		pending_items.push_back(it);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: zero axis, most negative and max components, angle corners
		add_item(16'h0000, 16'h0000, 16'h0000, 16'h2000);
		add_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		add_item(16'h8000, 16'h0000, 16'h0000, 16'h4000);
		add_item(16'h0000, 16'h8000, 16'h0000, 16'h8000);
		add_item(16'h0000, 16'h0000, 16'h8000, 16'hc000);
		add_item(16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
		add_item(16'h8000, 16'h8000, 16'h8000, 16'h0001);
		add_item(16'h0001, 16'h0000, 16'h0000, 16'h6000);
		add_item(16'h0000, 16'h0001, 16'hffff, 16'ha000);
		add_item(16'hffff, 16'h0001, 16'h0001, 16'he000);
		add_item(16'h7fff, 16'h8000, 16'h0001, 16'h7fff);
		add_item(16'h1234, 16'hedcb, 16'h5555, 16'haaaa);
		add_item(16'h0000, 16'h0000, 16'h0001, 16'h1fff);
		add_item(16'h0000, 16'h0000, 16'h0000, 16'hffff);
		wait (pending_items.size() == 0);
		drain_hold = 1'b1;
		wait (expected_matrices.size() == 0);
		@(negedge clk);
		drain_hold = 1'b0;

		for (int i = 0; i < 900; i++)
			add_item(rand_component(), rand_component(), rand_component(),
				16'($urandom));
		wait (pending_items.size() < 600);
		idle_pct = 0;
		wait (pending_items.size() < 400);
		idle_pct = 33;
		wait (pending_items.size() == 0);
		@(negedge clk);
		wait (expected_matrices.size() == 0);
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("axis_angle_rotation_matrix regression: pass");
		else
			$display("axis_angle_rotation_matrix regression: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("axis_angle_rotation_matrix regression: fail");
		$finish;
	end

endmodule
